// ----- hdl/dvrt_pkg.sv -----
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector routing table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int NODES_DEF     = 16;
    localparam int COST_BITS_DEF = 16;
    localparam int PAIR_CAP      = 5;
    localparam int ID_W          = 5;
    localparam int EXP_W         = 18;

    localparam logic [2:0] ACT_VECTOR = 3'd0;
    localparam logic [2:0] ACT_REMOTE = 3'd1;
    localparam logic [2:0] ACT_LOCAL  = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_TABLE  = 3'd4;
    localparam logic [2:0] ACT_PKTS   = 3'd5;

    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_COUNT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_NBR = 2'd1;
    localparam logic [1:0] ST_CRASHED = 2'd2;

    localparam logic [1:0] LINK_IDLE     = 2'd0;
    localparam logic [1:0] LINK_ACTIVE   = 2'd1;
    localparam logic [1:0] LINK_DISABLED = 2'd2;
    localparam logic [1:0] LINK_CRASHED  = 2'd3;

    localparam logic [1:0] REG_SELF  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_MASK  = 2'd2;
    localparam logic [1:0] REG_INTV  = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  sender;
        logic [4:0]  dest;
        logic [15:0] cost_value;
        logic        last_entry;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  row_dest;
        logic [15:0] distance;
        logic [4:0]  next_hop;
        logic [1:0]  status;
        logic [31:0] packet_count;
        logic        last;
    } result_t;

endpackage

// ----- hdl/dvrt_stream_if.sv -----
// ----------------------------------------------------------------------------
// dvrt_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface dvrt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/dvrt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dvrt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dvrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/dvrt_queue.sv -----
// ----------------------------------------------------------------------------
// dvrt_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module dvrt_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dvrt_pkg::item_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dvrt_pkg::item_t      out_data
);

    dvrt_pkg::item_t mem_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (out_valid && out_ready)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

endmodule

// ----- hdl/dvrt_engine.sv -----
// ----------------------------------------------------------------------------
// dvrt_engine
// Back part: link state, vector store, recompute walk and result output.
// ----------------------------------------------------------------------------
module dvrt_engine
#(
    parameter int NODES     = dvrt_pkg::NODES_DEF,
    parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  dvrt_pkg::item_t      cmd,
    input  logic [4:0]           self_id,
    input  logic [4:0]           node_count,
    input  logic [15:0]          nbr_mask,
    input  logic [15:0]          interval,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dvrt_pkg::result_t    res
);

    localparam int IW = $clog2(NODES);
    localparam int CW = IW + 1;
    localparam int AW = 2 * IW;
    localparam logic [COST_BITS-1:0] INF = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_TICK, S_CALC_RD, S_CALC, S_ROWS, S_ONE
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_reg;
    logic [COST_BITS-1:0]   vec_mem [NODES*NODES];
    logic [COST_BITS-1:0]   vec_rd_reg;
    logic [COST_BITS-1:0]   link_cost_reg [NODES];
    logic [1:0]             link_state_reg [NODES];
    logic [dvrt_pkg::EXP_W-1:0] expiry_reg [NODES];
    logic [COST_BITS-1:0]   best_reg [NODES];
    logic [4:0]             hop_reg [NODES];
    logic [31:0]            pkts_reg;
    logic [2:0]             pair_reg;
    logic [CW-1:0]          d_reg;
    logic [CW-1:0]          s_reg;
    logic [COST_BITS-1:0]   cur_best_reg;
    logic [4:0]             cur_hop_reg;
    logic                   crashed_reg;
    logic                   emit_reg;
    dvrt_pkg::result_t      one_reg;
    logic                   out_valid_reg;
    dvrt_pkg::result_t      out_reg;

    logic [CW-1:0]          used;
    logic                   snd_in_range;
    logic                   snd_nbr;
    logic [IW-1:0]          snd_idx;
    logic [IW-1:0]          dst_idx;
    logic                   out_free;
    logic [dvrt_pkg::EXP_W-1:0] exp_start;
    logic [COST_BITS:0]     sum;
    logic                   s_nbr;
    logic [dvrt_pkg::EXP_W-1:0] ecnt;

    function automatic logic nbr_of(input logic [CW-1:0] id, input logic [CW-1:0] u,
                                    input logic [4:0] sid, input logic [15:0] m);
        logic r;
        r = 1'b0;
        if (id >= CW'(1) && id <= u && 5'(id) != sid && 32'(id) <= 32'd16)
        begin
            r = m[4'(32'(id) - 32'd1)];
        end
        return r;
    endfunction

    assign used = (32'(node_count) < NODES) ? CW'(node_count) : CW'(NODES);
    assign snd_in_range = (cmd.sender >= 5'd1) && (32'(cmd.sender) <= 32'(used));
    assign snd_nbr = nbr_of(CW'(cmd.sender), used, self_id, nbr_mask)
                     && (32'(cmd.sender) <= NODES);
    assign snd_idx = IW'(cmd.sender - 5'd1);
    assign dst_idx = IW'(cmd.dest - 5'd1);
    assign exp_start = dvrt_pkg::EXP_W'({2'b00, interval} + {1'b0, interval, 1'b0});
    assign out_free = !out_valid_reg || res_ready;
    assign sum = {1'b0, vec_rd_reg} + {1'b0, link_cost_reg[IW'(s_reg)]};
    assign s_nbr = nbr_of(s_reg + CW'(1), used, self_id, nbr_mask);
    assign ecnt = expiry_reg[IW'(s_reg)];

    assign cmd_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE) || out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            vec_mem[clr_reg] <= INF;
        end
        else if (state_reg == S_IDLE && cmd_valid && cmd.action == dvrt_pkg::ACT_VECTOR
                 && pair_reg < 3'(dvrt_pkg::PAIR_CAP) && snd_nbr
                 && cmd.dest >= 5'd1 && 32'(cmd.dest) <= 32'(used))
        begin
            vec_mem[{snd_idx, dst_idx}] <= COST_BITS'(cmd.cost_value);
        end
        vec_rd_reg <= vec_mem[{IW'(s_reg), IW'(d_reg)}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pkts_reg      <= '0;
            pair_reg      <= '0;
            d_reg         <= '0;
            s_reg         <= '0;
            cur_best_reg  <= INF;
            cur_hop_reg   <= '0;
            crashed_reg   <= 1'b0;
            emit_reg      <= 1'b0;
            one_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                link_cost_reg[i]  <= INF;
                link_state_reg[i] <= dvrt_pkg::LINK_IDLE;
                expiry_reg[i]     <= '0;
                best_reg[i]       <= INF;
                hop_reg[i]        <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        d_reg <= '0;
                        s_reg <= '0;
                        cur_best_reg <= INF;
                        cur_hop_reg <= '0;
                        emit_reg <= 1'b1;
                        case (cmd.action)
                            dvrt_pkg::ACT_VECTOR:
                            begin
                                if (pair_reg < 3'(dvrt_pkg::PAIR_CAP))
                                begin
                                    if (snd_nbr)
                                    begin
                                        link_state_reg[snd_idx] <= dvrt_pkg::LINK_ACTIVE;
                                        expiry_reg[snd_idx] <= exp_start;
                                    end
                                    pair_reg <= pair_reg + 3'd1;
                                end
                                if (cmd.last_entry)
                                begin
                                    pkts_reg <= pkts_reg + 32'd1;
                                    pair_reg <= '0;
                                    state_reg <= S_CALC_RD;
                                end
                            end
                            dvrt_pkg::ACT_REMOTE, dvrt_pkg::ACT_LOCAL:
                            begin
                                if (cmd.action == dvrt_pkg::ACT_LOCAL && !snd_nbr)
                                begin
                                    one_reg <= '{dvrt_pkg::KIND_STATUS, 5'd0, 16'd0, 5'd0,
                                                 dvrt_pkg::ST_NOT_NBR, 32'd0, 1'b1};
                                    state_reg <= S_ONE;
                                end
                                else if (cmd.action == dvrt_pkg::ACT_LOCAL
                                         && link_state_reg[snd_idx] == dvrt_pkg::LINK_CRASHED)
                                begin
                                    one_reg <= '{dvrt_pkg::KIND_STATUS, 5'd0, 16'd0, 5'd0,
                                                 dvrt_pkg::ST_CRASHED, 32'd0, 1'b1};
                                    emit_reg <= 1'b0;
                                    state_reg <= S_CALC_RD;
                                end
                                else
                                begin
                                    if (snd_in_range && cmd.sender != self_id)
                                    begin
                                        link_cost_reg[snd_idx] <= COST_BITS'(cmd.cost_value);
                                        link_state_reg[snd_idx] <=
                                            (COST_BITS'(cmd.cost_value) == INF)
                                            ? dvrt_pkg::LINK_DISABLED : dvrt_pkg::LINK_ACTIVE;
                                        expiry_reg[snd_idx] <= exp_start;
                                    end
                                    state_reg <= S_CALC_RD;
                                end
                            end
                            dvrt_pkg::ACT_TICK:
                            begin
                                crashed_reg <= 1'b0;
                                state_reg <= S_TICK;
                            end
                            dvrt_pkg::ACT_TABLE:
                            begin
                                state_reg <= S_ROWS;
                            end
                            dvrt_pkg::ACT_PKTS:
                            begin
                                one_reg <= '{dvrt_pkg::KIND_COUNT, 5'd0, 16'd0, 5'd0,
                                             dvrt_pkg::ST_OK, pkts_reg, 1'b1};
                                pkts_reg <= '0;
                                state_reg <= S_ONE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_TICK:
                begin
                    if (s_nbr && link_state_reg[IW'(s_reg)] == dvrt_pkg::LINK_ACTIVE)
                    begin
                        if (ecnt <= dvrt_pkg::EXP_W'(1))
                        begin
                            expiry_reg[IW'(s_reg)] <= '0;
                            link_cost_reg[IW'(s_reg)] <= INF;
                            link_state_reg[IW'(s_reg)] <= dvrt_pkg::LINK_CRASHED;
                            crashed_reg <= 1'b1;
                        end
                        else
                        begin
                            expiry_reg[IW'(s_reg)] <= ecnt - dvrt_pkg::EXP_W'(1);
                        end
                    end
                    if (s_reg == CW'(NODES - 1))
                    begin
                        s_reg <= '0;
                        state_reg <= (crashed_reg || (s_nbr
                                      && link_state_reg[IW'(s_reg)] == dvrt_pkg::LINK_ACTIVE
                                      && ecnt <= dvrt_pkg::EXP_W'(1)))
                                     ? S_CALC_RD : S_IDLE;
                    end
                    else
                    begin
                        s_reg <= s_reg + CW'(1);
                    end
                end
                S_CALC_RD:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (d_reg >= used || 5'(d_reg + CW'(1)) == self_id || used == '0)
                    begin
                        best_reg[IW'(d_reg)] <= (d_reg < used) ? '0 : INF;
                        hop_reg[IW'(d_reg)] <= '0;
                        s_reg <= '0;
                        if (d_reg == CW'(NODES - 1))
                        begin
                            d_reg <= '0;
                            state_reg <= emit_reg ? S_ROWS : S_ONE;
                        end
                        else
                        begin
                            d_reg <= d_reg + CW'(1);
                            state_reg <= S_CALC_RD;
                        end
                    end
                    else
                    begin
                        if (s_nbr && vec_rd_reg != INF && link_cost_reg[IW'(s_reg)] != INF
                            && sum < {1'b0, INF} && sum < {1'b0, cur_best_reg})
                        begin
                            cur_best_reg <= COST_BITS'(sum);
                            cur_hop_reg <= 5'(s_reg + CW'(1));
                        end
                        if (s_reg + CW'(1) >= used)
                        begin
                            if (s_nbr && vec_rd_reg != INF && link_cost_reg[IW'(s_reg)] != INF
                                && sum < {1'b0, INF} && sum < {1'b0, cur_best_reg})
                            begin
                                best_reg[IW'(d_reg)] <= COST_BITS'(sum);
                                hop_reg[IW'(d_reg)] <= 5'(s_reg + CW'(1));
                            end
                            else
                            begin
                                best_reg[IW'(d_reg)] <= cur_best_reg;
                                hop_reg[IW'(d_reg)] <= cur_hop_reg;
                            end
                            cur_best_reg <= INF;
                            cur_hop_reg <= '0;
                            s_reg <= '0;
                            if (d_reg == CW'(NODES - 1))
                            begin
                                d_reg <= '0;
                                state_reg <= emit_reg ? S_ROWS : S_ONE;
                            end
                            else
                            begin
                                d_reg <= d_reg + CW'(1);
                                state_reg <= S_CALC_RD;
                            end
                        end
                        else
                        begin
                            s_reg <= s_reg + CW'(1);
                            state_reg <= S_CALC_RD;
                        end
                    end
                end
                S_ROWS:
                begin
                    if (d_reg >= used)
                    begin
                        d_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.kind <= dvrt_pkg::KIND_ROW;
                        out_reg.row_dest <= 5'(d_reg + CW'(1));
                        out_reg.distance <= (5'(d_reg + CW'(1)) == self_id) ? 16'd0
                                            : 16'(best_reg[IW'(d_reg)]);
                        out_reg.next_hop <= (5'(d_reg + CW'(1)) == self_id) ? 5'd0
                                            : hop_reg[IW'(d_reg)];
                        out_reg.status <= dvrt_pkg::ST_OK;
                        out_reg.packet_count <= '0;
                        out_reg.last <= (d_reg + CW'(1) == used);
                        d_reg <= d_reg + CW'(1);
                    end
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= one_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/dvrt_front.sv -----
// ----------------------------------------------------------------------------
// dvrt_front
// Front part: takes input transfers and configuration writes.
// ----------------------------------------------------------------------------
module dvrt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    dvrt_stream_if.sink          in_ch,
    dvrt_cfg_if.sink             cfg,
    output logic                 q_valid,
    input  logic                 q_ready,
    output dvrt_pkg::item_t      q_data,
    output logic [4:0]           self_id,
    output logic [4:0]           node_count,
    output logic [15:0]          nbr_mask,
    output logic [15:0]          interval
);

    logic [4:0]  self_reg;
    logic [4:0]  count_reg;
    logic [15:0] mask_reg;
    logic [15:0] intv_reg;

    assign in_ch.ready = q_ready;
    assign q_valid = in_ch.valid && (in_ch.data.action <= dvrt_pkg::ACT_PKTS);
    assign q_data = in_ch.data;
    assign cfg.ready = 1'b1;
    assign self_id = self_reg;
    assign node_count = count_reg;
    assign nbr_mask = mask_reg;
    assign interval = intv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg  <= 5'd1;
            count_reg <= 5'd16;
            mask_reg  <= '0;
            intv_reg  <= 16'd30;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dvrt_pkg::REG_SELF:  self_reg  <= cfg.wdata[4:0];
                dvrt_pkg::REG_COUNT: count_reg <= cfg.wdata[4:0];
                dvrt_pkg::REG_MASK:  mask_reg  <= cfg.wdata;
                dvrt_pkg::REG_INTV:  intv_reg  <= cfg.wdata;
                default:             self_reg  <= self_reg;
            endcase
        end
    end

endmodule

// ----- hdl/distance_vector_route_table.sv -----
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector routing table with Bellman-Ford recompute.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       action, sender, dest, cost_value, last_entry
// out_ch    source     kind, row_dest, distance, next_hop, status, packet_count, last
// cfg       sink       index, wdata
//
// A recompute walks each destination over all sources, with a registered read of
// the vector memory before each step; rows then leave one a cycle unless
// out_ch.ready stalls them. After reset the vector memory is cleared to INF.
// A two-entry queue separates input transfers from the engine.
// ----------------------------------------------------------------------------
module distance_vector_route_table
#(
    parameter int NODES     = dvrt_pkg::NODES_DEF,
    parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    dvrt_stream_if.sink in_ch,
    dvrt_stream_if.source out_ch,
    dvrt_cfg_if.sink    cfg
);

    logic                 q_in_valid;
    logic                 q_in_ready;
    dvrt_pkg::item_t      q_in_data;
    logic                 q_out_valid;
    logic                 q_out_ready;
    dvrt_pkg::item_t      q_out_data;
    logic [4:0]           self_id;
    logic [4:0]           node_count;
    logic [15:0]          nbr_mask;
    logic [15:0]          interval;
    logic                 busy;

    dvrt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .q_valid    (q_in_valid),
        .q_ready    (q_in_ready),
        .q_data     (q_in_data),
        .self_id    (self_id),
        .node_count (node_count),
        .nbr_mask   (nbr_mask),
        .interval   (interval)
    );

    dvrt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    dvrt_engine #(.NODES(NODES), .COST_BITS(COST_BITS)) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_out_valid),
        .cmd_ready  (q_out_ready),
        .cmd        (q_out_data),
        .self_id    (self_id),
        .node_count (node_count),
        .nbr_mask   (nbr_mask),
        .interval   (interval),
        .busy       (busy),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .res        (out_ch.data)
    );

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.kind != 2'd3)
        else $error("result kind out of range");

    a_status_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.kind == dvrt_pkg::KIND_ROW)
        |-> out_ch.data.status == dvrt_pkg::ST_OK)
        else $error("table row carries a status");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> busy)
        else $error("result pending while engine reports idle");

endmodule
